### sv/assert_macros.svh
// shared assertion macros clocked on clk; ASSERT_CLK is disabled while active-low rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/mcbm_pkg.sv
`default_nettype none
package mcbm_pkg;

  localparam int unsigned AddrW = 16;

  // request kinds
  localparam logic REQ_CPU_WRITE = 1'b0;
  localparam logic REQ_TICK      = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
  localparam logic [1:0] CFG_PATCH_MODE     = 2'd1;

  // address decode
  localparam logic [AddrW-1:0] ADDR_OUTER      = 16'h6000;
  localparam logic [AddrW-1:0] DEC_MASK        = 16'hE001;
  localparam logic [AddrW-1:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [AddrW-1:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [AddrW-1:0] REG_MIRROR      = 16'hA000;
  localparam logic [AddrW-1:0] REG_IRQ_COUNT   = 16'hC000;
  localparam logic [AddrW-1:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [AddrW-1:0] REG_IRQ_OFF     = 16'hE000;
  localparam logic [AddrW-1:0] REG_IRQ_ON      = 16'hE001;

  // bank data targets, bank_select[2:0]
  localparam logic [2:0] BD_CHR_R0 = 3'd0;
  localparam logic [2:0] BD_CHR_R1 = 3'd1;
  localparam logic [2:0] BD_CHR_R2 = 3'd2;
  localparam logic [2:0] BD_CHR_R3 = 3'd3;
  localparam logic [2:0] BD_CHR_R4 = 3'd4;
  localparam logic [2:0] BD_CHR_R5 = 3'd5;
  localparam logic [2:0] BD_PRG_R6 = 3'd6;
  localparam logic [2:0] BD_PRG_R7 = 3'd7;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [8:0] RESET_BANK_COUNT  = 9'd64;
  localparam logic [7:0] PATCH_LAST2       = 8'd62;
  localparam logic [7:0] PATCH_LAST1       = 8'd63;
  localparam logic [7:0] PRG_INNER_MASK    = 8'h3F;
  localparam logic [7:0] BASE_MASK_PATCH   = 8'hC0;
  localparam logic [7:0] BASE_MASK_NORMAL  = 8'hFF;
  localparam logic [1:0] HIGH_MASK_PATCH   = 2'b11;  // 0x30 >> 4
  localparam logic [1:0] HIGH_MASK_NORMAL  = 2'b01;  // 0x10 >> 4

  typedef logic [9:0] chr_bank_t;

  // inner character bank mask picked by outer reg 2 low nibble
  function automatic logic [7:0] chr_mask(input logic [3:0] sel);
    logic [7:0] m;
    case (sel)
      4'd8:    m = 8'h01;
      4'd9:    m = 8'h03;
      4'd10:   m = 8'h07;
      4'd11:   m = 8'h0F;
      4'd12:   m = 8'h1F;
      4'd13:   m = 8'h3F;
      4'd14:   m = 8'h7F;
      4'd15:   m = 8'hFF;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // inner program bank masked by outer reg 3, ORed with outer reg 1
  function automatic logic [7:0] outer_prg(input logic [7:0] inner, input logic [7:0] o1,
                                           input logic [7:0] o3);
    return ((inner & ~(o3 & PRG_INNER_MASK)) & PRG_INNER_MASK) | o1;
  endfunction

endpackage
`default_nettype wire

### sv/mcbm_if.sv
`default_nettype none
interface mcbm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [15:0] addr;
  logic [7:0] data;
  logic [8:0] line_number;
  logic       render_on;
  modport source (output valid, req_type, addr, data, line_number, render_on, input ready);
  modport sink   (input valid, req_type, addr, data, line_number, render_on, output ready);
endinterface

interface mcbm_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] prg_banks;
  logic [39:0] chr_banks_low;
  logic [39:0] chr_banks_high;
  logic        mirror_horizontal;
  logic        irq_pulse;
  modport source (output valid, prg_banks, chr_banks_low, chr_banks_high,
                  mirror_horizontal, irq_pulse, input ready);
  modport sink   (input valid, prg_banks, chr_banks_low, chr_banks_high,
                  mirror_horizontal, irq_pulse, output ready);
endinterface

interface mcbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [8:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

### sv/multicart_bank_mapper_with_scanline_irq.sv
// a word taken into the input register moves to the result register once that register is free
// throughput: one word per cycle unless stalled; a waiting result lets the input take one more word
// rate is set by the single state-update pass between the input and result registers
// reset: synchronous active-low rst_n clears control, bank count 64, patch off,
// program slots 0,1,62,63, character slots 0..7, irq and mirroring cleared
`default_nettype none
`include "assert_macros.svh"
module multicart_bank_mapper_with_scanline_irq (
  input  wire           clk,
  input  wire           rst_n,
  mcbm_req_if.sink      in_ch,
  mcbm_res_if.source    out_ch,
  mcbm_cfg_if.sink      cfg_ch
);

  // ---------------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------------
  logic        s1_valid_r;
  logic        s1_req_type_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic [8:0]  s1_line_r;
  logic        s1_render_r;

  logic out_valid_r;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_fire) begin
      s1_req_type_r <= in_ch.req_type;
      s1_addr_r     <= in_ch.addr;
      s1_data_r     <= in_ch.data;
      s1_line_r     <= in_ch.line_number;
      s1_render_r   <= in_ch.render_on;
    end
  end

  // ---------------------------------------------------------------------------
  // mapper state
  // ---------------------------------------------------------------------------
  logic [8:0]  rom_bank_count_r;
  logic        patch_mode_r;
  logic [7:0]  outer_r        [4];
  logic [1:0]  outer_index_r;
  logic [7:0]  bank_select_r;
  logic [7:0]  prg_logical_r  [4];
  logic [7:0]  prg_slot_r     [4];
  logic [7:0]  chr_logical_r  [8];
  mcbm_pkg::chr_bank_t chr_slot_r [8];
  logic        irq_enable_r;
  logic [7:0]  irq_count_r;
  logic [7:0]  irq_reload_r;
  logic        mirror_r;

  logic [7:0]  outer_nxt       [4];
  logic [1:0]  outer_index_nxt;
  logic [7:0]  bank_select_nxt;
  logic [7:0]  prg_logical_nxt [4];
  logic [7:0]  prg_slot_nxt    [4];
  logic [7:0]  chr_logical_nxt [8];
  mcbm_pkg::chr_bank_t chr_slot_nxt [8];
  logic        irq_enable_nxt;
  logic [7:0]  irq_count_nxt;
  logic [7:0]  irq_reload_nxt;
  logic        mirror_nxt;
  logic        pulse_nxt;

  logic        redo_prg;
  logic        redo_chr;
  logic [7:0]  chr_m;
  logic [7:0]  chr_base;
  logic [1:0]  chr_high;
  logic [15:0] dec_addr;
  logic [7:0]  data_even;
  logic [7:0]  swap_t;

  assign dec_addr  = s1_addr_r & mcbm_pkg::DEC_MASK;
  assign data_even = {s1_data_r[7:1], 1'b0};

  always_comb begin
    outer_nxt       = outer_r;
    outer_index_nxt = outer_index_r;
    bank_select_nxt = bank_select_r;
    prg_logical_nxt = prg_logical_r;
    prg_slot_nxt    = prg_slot_r;
    chr_logical_nxt = chr_logical_r;
    irq_enable_nxt  = irq_enable_r;
    irq_count_nxt   = irq_count_r;
    irq_reload_nxt  = irq_reload_r;
    mirror_nxt      = mirror_r;
    pulse_nxt       = 1'b0;
    redo_prg        = 1'b0;
    redo_chr        = 1'b0;
    swap_t          = prg_logical_r[0];

    if (s1_req_type_r == mcbm_pkg::REQ_TICK) begin
      // scanline counter clocks only while enabled, on visible lines with rendering on
      if (irq_enable_r && (s1_line_r <= mcbm_pkg::LAST_VISIBLE_LINE) && s1_render_r) begin
        if (irq_count_r == 8'd0) begin
          irq_count_nxt = irq_reload_r;
          pulse_nxt     = 1'b1;
        end else begin
          irq_count_nxt = irq_count_r - 8'd1;
        end
      end
    end else if (s1_addr_r == mcbm_pkg::ADDR_OUTER) begin
      // outer register write rotates through the four and rebuilds every slot
      outer_nxt[outer_index_r] = s1_data_r;
      outer_index_nxt          = outer_index_r + 2'd1;
      redo_prg                 = 1'b1;
      redo_chr                 = 1'b1;
    end else begin
      case (dec_addr)
        mcbm_pkg::REG_BANK_SELECT: begin
          // program mode flip swaps slots 0 and 2
          if (s1_data_r[6] != bank_select_r[6]) begin
            prg_logical_nxt[0] = prg_logical_r[2];
            prg_logical_nxt[2] = swap_t;
            prg_slot_nxt[0]    = prg_slot_r[2];
            prg_slot_nxt[2]    = prg_slot_r[0];
          end
          bank_select_nxt = s1_data_r;
        end
        mcbm_pkg::REG_BANK_DATA: begin
          case (bank_select_r[2:0])
            mcbm_pkg::BD_CHR_R0: begin
              chr_logical_nxt[0] = data_even;
              chr_logical_nxt[1] = {s1_data_r[7:1], 1'b1};
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_CHR_R1: begin
              chr_logical_nxt[2] = data_even;
              chr_logical_nxt[3] = {s1_data_r[7:1], 1'b1};
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_CHR_R2: begin
              chr_logical_nxt[4] = s1_data_r;
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_CHR_R3: begin
              chr_logical_nxt[5] = s1_data_r;
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_CHR_R4: begin
              chr_logical_nxt[6] = s1_data_r;
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_CHR_R5: begin
              chr_logical_nxt[7] = s1_data_r;
              redo_chr           = 1'b1;
            end
            mcbm_pkg::BD_PRG_R6: begin
              if (bank_select_r[6]) begin
                prg_logical_nxt[2] = s1_data_r & mcbm_pkg::PRG_INNER_MASK;
                prg_slot_nxt[2]    = mcbm_pkg::outer_prg(s1_data_r, outer_r[1], outer_r[3]);
              end else begin
                prg_logical_nxt[0] = s1_data_r & mcbm_pkg::PRG_INNER_MASK;
                prg_slot_nxt[0]    = mcbm_pkg::outer_prg(s1_data_r, outer_r[1], outer_r[3]);
              end
            end
            default: begin
              // R7 always drives program slot 1
              prg_logical_nxt[1] = s1_data_r & mcbm_pkg::PRG_INNER_MASK;
              prg_slot_nxt[1]    = mcbm_pkg::outer_prg(s1_data_r, outer_r[1], outer_r[3]);
            end
          endcase
        end
        mcbm_pkg::REG_MIRROR:     mirror_nxt     = s1_data_r[0];
        mcbm_pkg::REG_IRQ_COUNT:  irq_count_nxt  = s1_data_r;
        mcbm_pkg::REG_IRQ_RELOAD: irq_reload_nxt = s1_data_r;
        mcbm_pkg::REG_IRQ_OFF:    irq_enable_nxt = 1'b0;
        mcbm_pkg::REG_IRQ_ON:     irq_enable_nxt = 1'b1;
        default: ;
      endcase
    end

    if (redo_prg) begin
      for (int k = 0; k < 4; k++) begin
        prg_slot_nxt[k] = mcbm_pkg::outer_prg(prg_logical_nxt[k], outer_nxt[1], outer_nxt[3]);
      end
    end
  end

  // character rebuild: mask, outer base, two high bits from outer reg 2
  assign chr_m    = mcbm_pkg::chr_mask(outer_nxt[2][3:0]);
  assign chr_base = outer_nxt[0] &
                    (patch_mode_r ? mcbm_pkg::BASE_MASK_PATCH : mcbm_pkg::BASE_MASK_NORMAL);
  assign chr_high = outer_nxt[2][5:4] &
                    (patch_mode_r ? mcbm_pkg::HIGH_MASK_PATCH : mcbm_pkg::HIGH_MASK_NORMAL);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      chr_slot_nxt[k] = redo_chr ? {chr_high, (chr_logical_nxt[k] & chr_m) | chr_base}
                                 : chr_slot_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // configuration: to be written with no word in flight (not enforced); indexes 0,1 reload power-on program slots
  // ---------------------------------------------------------------------------
  logic       cfg_fire;
  logic [8:0] cfg_rbc;
  logic       cfg_patch;
  logic [7:0] cfg_last2;
  logic [7:0] cfg_last1;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign cfg_rbc      = (cfg_ch.reg_index == mcbm_pkg::CFG_ROM_BANK_COUNT) ? cfg_ch.wdata
                                                                          : rom_bank_count_r;
  assign cfg_patch    = (cfg_ch.reg_index == mcbm_pkg::CFG_PATCH_MODE) ? cfg_ch.wdata[0]
                                                                      : patch_mode_r;
  assign cfg_last2    = cfg_patch ? mcbm_pkg::PATCH_LAST2 : cfg_rbc[7:0] - 8'd2;
  assign cfg_last1    = cfg_patch ? mcbm_pkg::PATCH_LAST1 : cfg_rbc[7:0] - 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_count_r <= mcbm_pkg::RESET_BANK_COUNT;
      patch_mode_r     <= 1'b0;
      outer_index_r    <= 2'd0;
      bank_select_r    <= 8'd0;
      irq_enable_r     <= 1'b0;
      irq_count_r      <= 8'd0;
      irq_reload_r     <= 8'd0;
      mirror_r         <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        outer_r[k] <= 8'd0;
      end
      prg_logical_r[0] <= 8'd0;
      prg_logical_r[1] <= 8'd1;
      prg_logical_r[2] <= mcbm_pkg::RESET_BANK_COUNT[7:0] - 8'd2;
      prg_logical_r[3] <= mcbm_pkg::RESET_BANK_COUNT[7:0] - 8'd1;
      prg_slot_r[0]    <= 8'd0;
      prg_slot_r[1]    <= 8'd1;
      prg_slot_r[2]    <= mcbm_pkg::RESET_BANK_COUNT[7:0] - 8'd2;
      prg_slot_r[3]    <= mcbm_pkg::RESET_BANK_COUNT[7:0] - 8'd1;
      for (int k = 0; k < 8; k++) begin
        chr_logical_r[k] <= 8'(k);
        chr_slot_r[k]    <= 10'(k);
      end
    end else if (cfg_fire) begin
      if ((cfg_ch.reg_index == mcbm_pkg::CFG_ROM_BANK_COUNT) ||
          (cfg_ch.reg_index == mcbm_pkg::CFG_PATCH_MODE)) begin
        rom_bank_count_r <= cfg_rbc;
        patch_mode_r     <= cfg_patch;
        prg_logical_r[0] <= 8'd0;
        prg_logical_r[1] <= 8'd1;
        prg_logical_r[2] <= cfg_last2;
        prg_logical_r[3] <= cfg_last1;
        prg_slot_r[0]    <= 8'd0;
        prg_slot_r[1]    <= 8'd1;
        prg_slot_r[2]    <= cfg_last2;
        prg_slot_r[3]    <= cfg_last1;
      end
    end else if (s1_fire) begin
      outer_r       <= outer_nxt;
      outer_index_r <= outer_index_nxt;
      bank_select_r <= bank_select_nxt;
      prg_logical_r <= prg_logical_nxt;
      prg_slot_r    <= prg_slot_nxt;
      chr_logical_r <= chr_logical_nxt;
      chr_slot_r    <= chr_slot_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_count_r   <= irq_count_nxt;
      irq_reload_r  <= irq_reload_nxt;
      mirror_r      <= mirror_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register: packs the state left behind by this word
  // ---------------------------------------------------------------------------
  logic        invert;
  logic [31:0] prg_pack;
  logic [39:0] chr_lo_pack;
  logic [39:0] chr_hi_pack;

  // bit 7 of bank select swaps the two character halves, unless no program banks
  assign invert = bank_select_nxt[7] && (rom_bank_count_r != 9'd0);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prg_pack[8*k +: 8]     = prg_slot_nxt[k];
      chr_lo_pack[10*k +: 10] = invert ? chr_slot_nxt[k+4] : chr_slot_nxt[k];
      chr_hi_pack[10*k +: 10] = invert ? chr_slot_nxt[k]   : chr_slot_nxt[k+4];
    end
  end

  logic [31:0] out_prg_r;
  logic [39:0] out_chr_lo_r;
  logic [39:0] out_chr_hi_r;
  logic        out_mirror_r;
  logic        out_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_fire) begin
      out_prg_r    <= prg_pack;
      out_chr_lo_r <= chr_lo_pack;
      out_chr_hi_r <= chr_hi_pack;
      out_mirror_r <= mirror_nxt;
      out_pulse_r  <= pulse_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.prg_banks         = out_prg_r;
  assign out_ch.chr_banks_low     = out_chr_lo_r;
  assign out_ch.chr_banks_high    = out_chr_hi_r;
  assign out_ch.mirror_horizontal = out_mirror_r;
  assign out_ch.irq_pulse         = out_pulse_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(a_write_no_pulse, s1_fire && (s1_req_type_r == mcbm_pkg::REQ_CPU_WRITE) |=> !out_pulse_r, "cpu write raised irq pulse")
  `ASSERT_CLK(a_pulse_reloads, s1_fire && pulse_nxt && !cfg_fire |=> irq_count_r == $past(irq_reload_r), "irq pulse without counter reload")
  `ASSERT_CLK(a_outer_rotates, s1_fire && !cfg_fire && (s1_req_type_r == mcbm_pkg::REQ_CPU_WRITE) && (s1_addr_r == mcbm_pkg::ADDR_OUTER) |=> outer_index_r == 2'($past(outer_index_r) + 2'd1), "outer index did not advance")
  `ASSERT_CLK(a_stage_held, s1_valid_r && !out_free |=> s1_valid_r, "stalled word dropped from input stage")
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && !s1_valid_r, "valid state not cleared by reset")

endmodule
`default_nettype wire

### sim/multicart_bank_mapper_with_scanline_irq_tb.sv
`timescale 1ns / 100ps
module multicart_bank_mapper_with_scanline_irq_tb;

  // register indexes that the block decodes to nothing
  localparam logic [1:0] CFG_UNUSED2 = 2'd2;
  localparam logic [1:0] CFG_UNUSED3 = 2'd3;

  localparam int IDLE_PCT      = 11;   // chance per cycle that a side idles
  localparam int PHASE_ITEMS   = 138;  // random words per configuration phase
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 4;    // margin after the last queued view has come back
  localparam int HOLD_AT       = 400;  // result count that starts the long hold-off
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic        req_type;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line_number;
    logic        render_on;
  } map_req_t;

  typedef struct packed {
    logic [31:0] prg_banks;
    logic [39:0] chr_banks_low;
    logic [39:0] chr_banks_high;
    logic        mirror_horizontal;
    logic        irq_pulse;
  } map_res_t;

  // one directed word; known marks a result typed in by hand
  typedef struct packed {
    map_req_t req;
    logic     known;
    map_res_t res;
  } dir_row_t;

  // power-on view: program 0,1,62,63 and character 0..7
  localparam map_res_t BOOT_VIEW   = '{32'h3F3E_0100, 40'h00_C020_0400, 40'h01_C060_1404,
                                       1'b0, 1'b0};
  localparam map_res_t MIRROR_VIEW = '{32'h3F3E_0100, 40'h00_C020_0400, 40'h01_C060_1404,
                                       1'b1, 1'b0};
  // program slots 0 and 2 exchanged
  localparam map_res_t SWAP_VIEW   = '{32'h3F00_013E, 40'h00_C020_0400, 40'h01_C060_1404,
                                       1'b0, 1'b0};
  // character halves shown the other way round
  localparam map_res_t INVERT_VIEW = '{32'h3F3E_0100, 40'h01_C060_1404, 40'h00_C020_0400,
                                       1'b0, 1'b0};
  // program slot 1 loaded with 0x3f
  localparam map_res_t R7_VIEW     = '{32'h3F3E_3F00, 40'h00_C020_0400, 40'h01_C060_1404,
                                       1'b0, 1'b0};
  localparam map_res_t NO_VIEW     = '0;

  localparam int NUM_DIRECTED = 28;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // irq still disabled, so a visible tick changes nothing
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd0, 1'b1}, 1'b1, BOOT_VIEW},
    // near miss of the outer register, and the low space
    '{'{mcbm_pkg::REQ_CPU_WRITE, 16'h6002, 8'hFF, 9'd0, 1'b0}, 1'b1, BOOT_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, 16'h7FFF, 8'hAA, 9'd0, 1'b0}, 1'b1, BOOT_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_MIRROR, 8'h01, 9'd0, 1'b0}, 1'b1, MIRROR_VIEW},
    // mirror alias at the top of its window, bit 0 clear
    '{'{mcbm_pkg::REQ_CPU_WRITE, 16'hBFFE, 8'hFE, 9'd0, 1'b0}, 1'b1, BOOT_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_SELECT, 8'h40, 9'd0, 1'b0}, 1'b1, SWAP_VIEW},
    // bit 6 drops back and bit 7 inverts the character halves
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_SELECT, 8'h80, 9'd0, 1'b0}, 1'b1,
      INVERT_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, 16'h9FFE, 8'h07, 9'd0, 1'b0}, 1'b1, BOOT_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_DATA, 8'hFF, 9'd0, 1'b0}, 1'b1, R7_VIEW},
    // from here on the predictor supplies the result
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_SELECT, 8'h46, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_DATA, 8'hFF, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_SELECT, 8'h00, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_DATA, 8'hFF, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_SELECT, 8'h85, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_BANK_DATA, 8'h00, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    // all four outer registers in turn
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::ADDR_OUTER, 8'hFF, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::ADDR_OUTER, 8'h80, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::ADDR_OUTER, 8'h1F, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::ADDR_OUTER, 8'h3F, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_IRQ_COUNT, 8'h00, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_IRQ_RELOAD, 8'h02, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_IRQ_ON, 8'h00, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    // counter at zero reloads and pulses, then counts down
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd0, 1'b1}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd239, 1'b1}, 1'b0, NO_VIEW},
    // off the visible lines, then rendering off
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd240, 1'b1}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd100, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_CPU_WRITE, mcbm_pkg::REG_IRQ_OFF, 8'h00, 9'd0, 1'b0}, 1'b0, NO_VIEW},
    '{'{mcbm_pkg::REQ_TICK, 16'h0000, 8'h00, 9'd5, 1'b1}, 1'b0, NO_VIEW}
  };

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mcbm_req_if in_ch ();
  mcbm_res_if out_ch ();
  mcbm_cfg_if cfg_ch ();

  multicart_bank_mapper_with_scanline_irq dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mapper state as the predictor sees it
  logic [8:0] m_bank_count;
  logic       m_patch;
  logic [7:0] m_outer [4];
  logic [1:0] m_outer_idx;
  logic [7:0] m_bank_sel;
  logic [7:0] m_prg_inner [4];
  logic [7:0] m_prg_slot [4];
  logic [7:0] m_chr_inner [8];
  logic [9:0] m_chr_slot [8];
  logic       m_irq_en;
  logic [7:0] m_irq_cnt;
  logic [7:0] m_irq_reload;
  logic       m_mirror;

  map_res_t    expected_views [$];
  int unsigned views_checked = 0;
  int unsigned mismatch_count = 0;
  logic        no_idle = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // inner program bank: low six bits not masked by outer reg 3, then outer reg 1 on top
  function automatic logic [7:0] prg_map(input logic [7:0] inner);
    logic [5:0] keep;
    keep = ~m_outer[3][5:0];
    return {2'b00, inner[5:0] & keep} | m_outer[1];
  endfunction

  // all eight character slots from their inner banks and the outer registers
  function automatic void refresh_chr();
    logic [7:0] inner_mask;
    logic [7:0] base;
    logic [9:0] high;
    int         k;
    inner_mask = m_outer[2][3] ? (8'hFF >> (3'd7 - m_outer[2][2:0])) : 8'h00;
    base = m_outer[0] & (m_patch ? mcbm_pkg::BASE_MASK_PATCH : mcbm_pkg::BASE_MASK_NORMAL);
    high = {m_outer[2][5:4] & (m_patch ? mcbm_pkg::HIGH_MASK_PATCH : mcbm_pkg::HIGH_MASK_NORMAL),
            8'h00};
    for (k = 0; k < 8; k++)
      m_chr_slot[k] = {2'b00, (m_chr_inner[k] & inner_mask) | base} + high;
  endfunction

  // power-on program banks for the current bank count and patch setting
  function automatic void load_boot_prg();
    int k;
    m_prg_inner[0] = 8'd0;
    m_prg_inner[1] = 8'd1;
    if (m_patch) begin
      m_prg_inner[2] = mcbm_pkg::PATCH_LAST2;
      m_prg_inner[3] = mcbm_pkg::PATCH_LAST1;
    end else begin
      m_prg_inner[2] = 8'(m_bank_count - 9'd2);
      m_prg_inner[3] = 8'(m_bank_count - 9'd1);
    end
    for (k = 0; k < 4; k++)
      m_prg_slot[k] = m_prg_inner[k];
  endfunction

  // applies one request word and returns the bank view that follows it
  function automatic map_res_t bank_view_after(input map_req_t r);
    map_res_t   v;
    logic       flip;
    logic [7:0] t;
    int         k;
    v = '0;
    if (r.req_type == mcbm_pkg::REQ_TICK) begin
      if (m_irq_en && r.line_number <= mcbm_pkg::LAST_VISIBLE_LINE && r.render_on) begin
        if (m_irq_cnt == 8'd0) begin
          m_irq_cnt = m_irq_reload;
          v.irq_pulse = 1'b1;
        end else begin
          m_irq_cnt = m_irq_cnt - 8'd1;
        end
      end
    end else if (r.addr == mcbm_pkg::ADDR_OUTER) begin
      // outer write rotates the index and remaps everything
      m_outer[m_outer_idx] = r.data;
      m_outer_idx = m_outer_idx + 2'd1;
      for (k = 0; k < 4; k++)
        m_prg_slot[k] = prg_map(m_prg_inner[k]);
      refresh_chr();
    end else begin
      case (r.addr & mcbm_pkg::DEC_MASK)
        mcbm_pkg::REG_BANK_SELECT: begin
          // program mode flip exchanges slots 0 and 2
          if (r.data[6] != m_bank_sel[6]) begin
            t = m_prg_inner[0];
            m_prg_inner[0] = m_prg_inner[2];
            m_prg_inner[2] = t;
            t = m_prg_slot[0];
            m_prg_slot[0] = m_prg_slot[2];
            m_prg_slot[2] = t;
          end
          m_bank_sel = r.data;
        end
        mcbm_pkg::REG_BANK_DATA: begin
          case (m_bank_sel[2:0])
            mcbm_pkg::BD_CHR_R0: begin
              m_chr_inner[0] = {r.data[7:1], 1'b0};
              m_chr_inner[1] = {r.data[7:1], 1'b1};
              refresh_chr();
            end
            mcbm_pkg::BD_CHR_R1: begin
              m_chr_inner[2] = {r.data[7:1], 1'b0};
              m_chr_inner[3] = {r.data[7:1], 1'b1};
              refresh_chr();
            end
            mcbm_pkg::BD_CHR_R2: begin
              m_chr_inner[4] = r.data;
              refresh_chr();
            end
            mcbm_pkg::BD_CHR_R3: begin
              m_chr_inner[5] = r.data;
              refresh_chr();
            end
            mcbm_pkg::BD_CHR_R4: begin
              m_chr_inner[6] = r.data;
              refresh_chr();
            end
            mcbm_pkg::BD_CHR_R5: begin
              m_chr_inner[7] = r.data;
              refresh_chr();
            end
            mcbm_pkg::BD_PRG_R6: begin
              if (m_bank_sel[6]) begin
                m_prg_inner[2] = {2'b00, r.data[5:0]};
                m_prg_slot[2] = prg_map(r.data);
              end else begin
                m_prg_inner[0] = {2'b00, r.data[5:0]};
                m_prg_slot[0] = prg_map(r.data);
              end
            end
            default: begin
              m_prg_inner[1] = {2'b00, r.data[5:0]};
              m_prg_slot[1] = prg_map(r.data);
            end
          endcase
        end
        mcbm_pkg::REG_MIRROR:     m_mirror = r.data[0];
        mcbm_pkg::REG_IRQ_COUNT:  m_irq_cnt = r.data;
        mcbm_pkg::REG_IRQ_RELOAD: m_irq_reload = r.data;
        mcbm_pkg::REG_IRQ_OFF:    m_irq_en = 1'b0;
        mcbm_pkg::REG_IRQ_ON:     m_irq_en = 1'b1;
        default: ;
      endcase
    end
    // inversion is suppressed when the bank count is zero
    flip = m_bank_sel[7] && (m_bank_count != 9'd0);
    for (k = 0; k < 4; k++) begin
      v.prg_banks[8*k +: 8] = m_prg_slot[k];
      v.chr_banks_low[10*k +: 10] = flip ? m_chr_slot[k+4] : m_chr_slot[k];
      v.chr_banks_high[10*k +: 10] = flip ? m_chr_slot[k] : m_chr_slot[k+4];
    end
    v.mirror_horizontal = m_mirror;
    return v;
  endfunction

  // offers one word, with random idle cycles in front, and queues its view once taken
  task automatic send_word(input map_req_t r, input logic known, input map_res_t typed);
    map_res_t pred;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= r.req_type;
    in_ch.addr        <= r.addr;
    in_ch.data        <= r.data;
    in_ch.line_number <= r.line_number;
    in_ch.render_on   <= r.render_on;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // word taken at this edge; the predictor always runs to keep its state in step
    pred = bank_view_after(r);
    expected_views.push_back(known ? typed : pred);
  endtask

  // register write; the caller lowers valid after its last write
  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    // either real register reloads the power-on program banks
    case (idx)
      mcbm_pkg::CFG_ROM_BANK_COUNT: begin
        m_bank_count = val;
        load_boot_prg();
      end
      mcbm_pkg::CFG_PATCH_MODE: begin
        m_patch = val[0];
        load_boot_prg();
      end
      default: ;
    endcase
  endtask

  // stop offering and wait until every queued view has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random request or short well-formed sequence; sent counts the words that matter
  task automatic send_random_burst(inout int unsigned sent);
    map_req_t    r;
    int unsigned pick;
    int unsigned run;
    r.req_type    = mcbm_pkg::REQ_CPU_WRITE;
    r.addr        = 16'($urandom);
    r.data        = 8'($urandom);
    r.line_number = 9'($urandom);
    r.render_on   = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) begin
      // bank select then bank data, through random aliases
      r.addr = mcbm_pkg::REG_BANK_SELECT | (16'($urandom) & 16'h1FFE);
      send_word(r, 1'b0, NO_VIEW);
      r.addr = mcbm_pkg::REG_BANK_DATA | (16'($urandom) & 16'h1FFE);
      r.data = 8'($urandom);
      send_word(r, 1'b0, NO_VIEW);
      sent += 2;
    end else if (pick < 42) begin
      r.addr = mcbm_pkg::ADDR_OUTER;
      send_word(r, 1'b0, NO_VIEW);
      sent += 1;
    end else if (pick < 67) begin
      // mostly visible lines with rendering on
      r.req_type = mcbm_pkg::REQ_TICK;
      r.line_number = ($urandom_range(99) < 85) ? 9'($urandom_range(239))
                                                 : 9'($urandom_range(511, 240));
      r.render_on = ($urandom_range(99) < 90);
      send_word(r, 1'b0, NO_VIEW);
      sent += 1;
    end else if (pick < 77) begin
      // irq registers, small counts so that pulses come often
      case ($urandom_range(5))
        0, 1:    r.addr = mcbm_pkg::REG_IRQ_COUNT;
        2:       r.addr = mcbm_pkg::REG_IRQ_RELOAD;
        3:       r.addr = mcbm_pkg::REG_IRQ_OFF;
        default: r.addr = mcbm_pkg::REG_IRQ_ON;
      endcase
      r.addr = r.addr | (16'($urandom) & 16'h1FFE);
      if ($urandom_range(1) == 0) r.data = 8'($urandom_range(7));
      send_word(r, 1'b0, NO_VIEW);
      sent += 1;
    end else if (pick < 83) begin
      r.addr = mcbm_pkg::REG_MIRROR | (16'($urandom) & 16'h1FFE);
      send_word(r, 1'b0, NO_VIEW);
      sent += 1;
    end else if (pick < 88) begin
      // a run of visible ticks walks the counter down
      r.req_type = mcbm_pkg::REQ_TICK;
      r.render_on = 1'b1;
      for (run = $urandom_range(6, 2); run != 0; run--) begin
        r.line_number = 9'($urandom_range(239));
        send_word(r, 1'b0, NO_VIEW);
        sent += 1;
      end
    end else begin
      // noise: any address, or a tick on any line
      if ($urandom_range(3) == 0) r.req_type = mcbm_pkg::REQ_TICK;
      send_word(r, 1'b0, NO_VIEW);
      if (r.req_type == mcbm_pkg::REQ_TICK || r.addr[15] || r.addr == mcbm_pkg::ADDR_OUTER)
        sent += 1;
    end
  endtask

  // result side: checks every word taken and decides ready for the next edge
  always @(posedge clk) begin : result_check
    map_res_t got;
    map_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.prg_banks, out_ch.chr_banks_low, out_ch.chr_banks_high,
                out_ch.mirror_horizontal, out_ch.irq_pulse};
        if (expected_views.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result word %0d arrived with nothing queued", views_checked);
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("bad result word %0d", views_checked);
              $display("  prg exp %h got %h  mirror exp %b got %b  irq exp %b got %b",
                       want.prg_banks, got.prg_banks, want.mirror_horizontal,
                       got.mirror_horizontal, want.irq_pulse, got.irq_pulse);
              $display("  chr lo exp %h got %h  chr hi exp %h got %h",
                       want.chr_banks_low, got.chr_banks_low,
                       want.chr_banks_high, got.chr_banks_high);
            end
          end
        end
        views_checked++;
      end
      // one long hold-off fills the block while the sender keeps offering
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && views_checked >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int          i;
    int          k;
    int          ph;
    int unsigned sent;
    logic [8:0]  bank_count;
    logic        patch;
    // every input known from time zero; result ready comes from the checker
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= mcbm_pkg::REQ_CPU_WRITE;
    in_ch.addr        <= '0;
    in_ch.data        <= '0;
    in_ch.line_number <= '0;
    in_ch.render_on   <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= mcbm_pkg::CFG_ROM_BANK_COUNT;
    cfg_ch.wdata      <= '0;

    // predictor starts from the power-on state
    m_bank_count = mcbm_pkg::RESET_BANK_COUNT;
    m_patch      = 1'b0;
    m_outer_idx  = 2'd0;
    m_bank_sel   = 8'd0;
    m_irq_en     = 1'b0;
    m_irq_cnt    = 8'd0;
    m_irq_reload = 8'd0;
    m_mirror     = 1'b0;
    for (k = 0; k < 4; k++) m_outer[k] = 8'd0;
    for (k = 0; k < 8; k++) begin
      m_chr_inner[k] = 8'(k);
      m_chr_slot[k]  = 10'(k);
    end
    load_boot_prg();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset settings
    for (i = 0; i < NUM_DIRECTED; i++)
      send_word(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].res);

    // random phases, each at its own bank count and patch setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: begin bank_count = 9'd2;   patch = 1'b0; end
          2: begin bank_count = 9'd256; patch = 1'b0; end
          3: begin bank_count = 9'd0;   patch = 1'b0; end
          4: begin bank_count = 9'd511; patch = 1'b1; end
          5: begin bank_count = 9'd1;   patch = 1'b0; end
          6: begin bank_count = 9'($urandom_range(256, 2)); patch = 1'b1; end
          default: begin
            bank_count = 9'($urandom);
            patch = 1'($urandom);
          end
        endcase
        // the spare indexes must leave everything alone
        if (ph == NUM_PHASES - 1) begin
          cfg_write(CFG_UNUSED2, 9'($urandom));
          cfg_write(CFG_UNUSED3, 9'($urandom));
        end
        cfg_write(mcbm_pkg::CFG_ROM_BANK_COUNT, bank_count);
        // upper bits of the patch write are don't-care
        cfg_write(mcbm_pkg::CFG_PATCH_MODE, (9'($urandom) & 9'h1FE) | {8'h00, patch});
        cfg_ch.valid <= 1'b0;
      end
      // phase two runs with no idling on either side
      no_idle <= (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_burst(sent);
    end

    settle();
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
